[design/bcc_pkg.sv]
`default_nettype none

package bcc_pkg;

	localparam int K_MAX_DEF = 1024;
	localparam int CAP_W     = 11;
	localparam int WAYS_W    = 30;

	localparam logic [WAYS_W-1:0] PRIME = 30'd1000000007;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;   // latch cap, first flag and target; restart the sweep
		logic issue;  // read one prefix entry pair, step the index
		logic flip;   // swap prefix banks at the end of the sweep
	} dp_cmd_t;

	typedef struct packed {
		logic last;        // index is at K_MAX
		logic pipe_empty;  // no entry in flight
	} dp_stat_t;

	function automatic logic [WAYS_W-1:0] mod_add(input logic [WAYS_W-1:0] x,
		input logic [WAYS_W-1:0] y);
		logic [WAYS_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[WAYS_W-1:0];
	endfunction

	function automatic logic [WAYS_W-1:0] mod_sub(input logic [WAYS_W-1:0] x,
		input logic [WAYS_W-1:0] y);
		logic [WAYS_W-1:0] r;
		if (x >= y) begin
			r = x - y;
		end else begin
			r = x + (PRIME - y);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/bcc_ram.sv]
`default_nettype none

module bcc_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1025,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/bcc_ctrl.sv]
`default_nettype none

module bcc_ctrl
	import bcc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (stat.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				cmd.flip = stat.pipe_empty;
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/bcc_dp.sv]
`default_nettype none

module bcc_dp
	import bcc_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	input  wire logic              first_item,
	input  wire logic [CAP_W-1:0]  cap,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  k_total,
	output logic      [WAYS_W-1:0] ways
);

	localparam int AW = $clog2(K_MAX + 1);
	localparam int EW = (AW > CAP_W) ? AW : CAP_W;
	localparam logic [EW-1:0] KLIM = EW'(K_MAX);

	logic [CAP_W-1:0] k_total_q;
	logic             bank_q;

	logic [AW-1:0]    cap_q;
	logic [AW-1:0]    target_q;
	logic             first_q;
	logic [AW-1:0]    j_q;

	logic             v_s1;
	logic [AW-1:0]    j_s1;
	logic             sub_en_s1;

	logic              v_s2;
	logic [AW-1:0]     j_s2;
	logic [WAYS_W-1:0] w_s2;

	logic [WAYS_W-1:0] run_q;
	logic [WAYS_W-1:0] ways_q;

	logic [EW-1:0]     cap_ext;
	logic [EW-1:0]     tgt_ext;
	logic [EW-1:0]     cap_sat;
	logic [EW-1:0]     tgt_sat;
	logic              sub_en;
	logic [AW-1:0]     raddr0;
	logic [AW-1:0]     raddr1;
	logic [WAYS_W-1:0] rd_data [2][2];
	logic [WAYS_W-1:0] rd0;
	logic [WAYS_W-1:0] rd1;
	logic [WAYS_W-1:0] w_d;
	logic [WAYS_W-1:0] wsum;
	logic [1:0]        wr_en;

	assign cap_ext = EW'(cap);
	assign tgt_ext = EW'(k_total_q);
	assign cap_sat = (cap_ext > KLIM) ? KLIM : cap_ext;
	assign tgt_sat = (tgt_ext > KLIM) ? KLIM : tgt_ext;

	// windowed difference reads P[j] and P[j-cap-1]
	assign sub_en = (j_q > cap_q);
	assign raddr0 = j_q;
	assign raddr1 = sub_en ? (j_q - cap_q - AW'(1)) : '0;

	// bank_q names the bank holding the latest prefix sums
	assign rd0 = bank_q ? rd_data[1][0] : rd_data[0][0];
	assign rd1 = bank_q ? rd_data[1][1] : rd_data[0][1];

	assign w_d = first_q ? ((j_s1 <= cap_q) ? WAYS_W'(1) : '0)
	                     : mod_sub(rd0, sub_en_s1 ? rd1 : '0);

	assign wsum = mod_add(run_q, w_s2);

	assign wr_en[0] = v_s2 & bank_q;
	assign wr_en[1] = v_s2 & ~bank_q;

	// two copies per bank give two reads per cycle
	for (genvar b = 0; b < 2; b++) begin : g_bank
		for (genvar c = 0; c < 2; c++) begin : g_copy
			bcc_ram #(
				.WIDTH (WAYS_W),
				.DEPTH (K_MAX + 1)
			) u_ram (
				.clk   (clk),
				.we    (wr_en[b]),
				.waddr (j_s2),
				.wdata (wsum),
				.raddr ((c == 0) ? raddr0 : raddr1),
				.rdata (rd_data[b][c])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_total_q <= '0;
			bank_q    <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (cfg_we) k_total_q <= k_total;
			if (cmd.flip) bank_q <= ~bank_q;
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cap_q    <= AW'(cap_sat);
			target_q <= AW'(tgt_sat);
			first_q  <= first_item;
			j_q      <= '0;
			run_q    <= '0;
		end else begin
			if (cmd.issue) j_q <= j_q + AW'(1);
			if (v_s2) run_q <= wsum;
		end
		j_s1      <= j_q;
		sub_en_s1 <= sub_en;
		j_s2      <= j_s1;
		w_s2      <= w_d;
		if (v_s2 && (j_s2 == target_q)) ways_q <= w_s2;
	end

	assign stat.last       = (j_q == AW'(K_MAX));
	assign stat.pipe_empty = ~v_s1 & ~v_s2;
	assign ways            = ways_q;

endmodule

`default_nettype wire

[design/bounded_composition_counter.sv]
// Items are taken one at a time: ways is valid with out_valid, after the sweep
// over prefix entries 0..K_MAX (one entry per cycle through the RAM ports) has
// drained; a new input beat is taken only after out_ready accepts the result.
// Reset: arst_n (async, active low) clears the controller, bank select,
// pipeline valids and k_total; prefix RAM contents are not cleared.
`default_nettype none

module bounded_composition_counter
	import bcc_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CAP_W-1:0]  k_total,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              first_item,
	input  wire logic [CAP_W-1:0]  cap,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [WAYS_W-1:0] ways
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bcc_dp #(
		.K_MAX (K_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.first_item (first_item),
		.cap        (cap),
		.cfg_we     (cfg_valid & cfg_ready),
		.k_total    (k_total),
		.ways       (ways)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input beat taken while an item is in work");

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_flip_before_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.flip))
		else $error("result shown without a bank swap");

	a_ways_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ways < PRIME))
		else $error("ways not reduced modulo prime");

endmodule

`default_nettype wire
